@@ rtl/core/lpla_pkg.sv @@
// ----------------------------------------------------------------------------
// lpla_pkg
// Shared types, constants and helpers of the list page layout allocator.
// ----------------------------------------------------------------------------
package lpla_pkg;

   localparam int CHUNK_NODES = 512;
   localparam int NODE_W      = $clog2(CHUNK_NODES);

   localparam int EPP_W         = 16;
   localparam logic [EPP_W-1:0] EPP_RESET = 16'd512;

   // dividend is list size plus the page fill, so one bit wider than a count
   localparam int DIVIDEND_W = 33;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] KIND_LARGE = 2'd0;
   localparam logic [1:0] KIND_CHUNK = 2'd1;
   localparam logic [1:0] KIND_TOTAL = 2'd2;

   typedef struct packed {
      logic [31:0] list_size;
      logic        is_large;
      logic        final_node;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [31:0] record_index;
      logic [31:0] page_count;
      logic [31:0] element_count;
      logic [31:0] first_page;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic apply_small;
      logic emit_large;
      logic emit_chunk;
      logic emit_total;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic is_large;
      logic close_chunk;
      logic final_node;
      logic rsp_free;
   } status_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

@@ rtl/core/lpla_divider.sv @@
// ----------------------------------------------------------------------------
// lpla_divider
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 16 bits.
// ----------------------------------------------------------------------------
module lpla_divider
   import lpla_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [EPP_W-1:0]      divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [EPP_W-1:0]      remainder
);

   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [EPP_W-1:0]      rem_ff, rem_in;
   logic [EPP_W-1:0]      div_ff, div_in;
   logic [EPP_W:0]        rem_shift;
   logic                  ge;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge        = rem_shift >= {1'b0, div_ff};
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         count_in = DIV_CNT_W'(DIV_STEPS);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         quo_in   = {quo_ff[DIVIDEND_W-2:0], ge};
         rem_in   = ge ? EPP_W'(rem_shift - {1'b0, div_ff}) : rem_shift[EPP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = (count_ff == '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/lpla_datapath.sv @@
// ----------------------------------------------------------------------------
// lpla_datapath
// Layout state, page arithmetic and the result register of the allocator.
// ----------------------------------------------------------------------------
module lpla_datapath
   import lpla_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [EPP_W-1:0]  csr_write_data,
   input  req_type           req_data,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   logic [EPP_W-1:0]  epp_ff, epp_in;
   logic [NODE_W-1:0] nodes_ff, nodes_in;
   logic [EPP_W-1:0]  fill_ff, fill_in;
   logic [31:0]       cfp_ff, cfp_in;
   logic [31:0]       nfp_ff, nfp_in;
   logic [31:0]       llc_ff, llc_in;
   logic [31:0]       chunk_ff, chunk_in;
   logic              large_ff, large_in;
   logic              final_ff, final_in;
   logic              close_ff, close_in;
   logic [31:0]       size_ff, size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [EPP_W-1:0]      epp_eff;
   logic [DIVIDEND_W-1:0] dividend;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] quo;
   logic [EPP_W-1:0]      rem;
   logic [31:0]           large_pages;
   logic [31:0]           chunk_pages;
   logic [DIVIDEND_W-1:0] left;
   logic [31:0]           left_sat;
   logic [EPP_W-1:0]      small_fill;
   logic                  close_now;

   lpla_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .dividend  (dividend),
      .divisor   (epp_eff),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   always_comb begin
      epp_eff   = (epp_ff == '0) ? EPP_W'(1) : epp_ff;
      dividend  = req_data.is_large ? {1'b0, req_data.list_size}
                                    : {1'b0, req_data.list_size} + DIVIDEND_W'(fill_ff);
      close_now = (nodes_ff == NODE_W'(CHUNK_NODES - 1)) || req_data.final_node;

      large_pages = quo[31:0] + {31'b0, rem != '0};
      chunk_pages = sat_add(cfp_ff, {31'b0, fill_ff != '0});

      // a page filled exactly stays current, so an even split leaves one less
      if (quo == '0 && rem == '0) begin
         left       = '0;
         small_fill = '0;
      end else if (rem != '0) begin
         left       = quo;
         small_fill = rem;
      end else begin
         left       = quo - 1'b1;
         small_fill = epp_eff;
      end
      left_sat = left[DIVIDEND_W-1] ? 32'hFFFF_FFFF : left[31:0];

      epp_in       = csr_write_en ? csr_write_data : epp_ff;
      nodes_in     = nodes_ff;
      fill_in      = fill_ff;
      cfp_in       = cfp_ff;
      nfp_in       = nfp_ff;
      llc_in       = llc_ff;
      chunk_in     = chunk_ff;
      large_in     = large_ff;
      final_in     = final_ff;
      close_in     = close_ff;
      size_in      = size_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.start) begin
         size_in  = req_data.list_size;
         large_in = req_data.is_large;
         final_in = req_data.final_node;
         close_in = close_now;
         nodes_in = close_now ? '0 : NODE_W'(nodes_ff + 1'b1);
      end

      if (cmd.apply_small) begin
         fill_in = small_fill;
         cfp_in  = sat_add(cfp_ff, left_sat);
      end

      if (cmd.emit_large) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.record_kind   = KIND_LARGE;
         rsp_data_in.record_index  = llc_ff;
         rsp_data_in.page_count    = large_pages;
         rsp_data_in.element_count = size_ff;
         rsp_data_in.first_page    = nfp_ff;
         rsp_data_in.last_result   = cmd.last;
         nfp_in = sat_add(nfp_ff, large_pages);
         llc_in = sat_add(llc_ff, 32'd1);
      end

      if (cmd.emit_chunk) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.record_kind   = KIND_CHUNK;
         rsp_data_in.record_index  = chunk_ff;
         rsp_data_in.page_count    = chunk_pages;
         rsp_data_in.element_count = '0;
         rsp_data_in.first_page    = nfp_ff;
         rsp_data_in.last_result   = cmd.last;
         nfp_in   = sat_add(nfp_ff, chunk_pages);
         chunk_in = sat_add(chunk_ff, 32'd1);
         fill_in  = '0;
         cfp_in   = '0;
      end

      if (cmd.emit_total) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.record_kind   = KIND_TOTAL;
         rsp_data_in.record_index  = '0;
         rsp_data_in.page_count    = nfp_ff;
         rsp_data_in.element_count = '0;
         rsp_data_in.first_page    = '0;
         rsp_data_in.last_result   = 1'b1;
         // end of the set: back to the reset layout, register kept
         nodes_in = '0;
         fill_in  = '0;
         cfp_in   = '0;
         nfp_in   = '0;
         llc_in   = '0;
         chunk_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epp_ff       <= EPP_RESET;
         nodes_ff     <= '0;
         fill_ff      <= '0;
         cfp_ff       <= '0;
         nfp_ff       <= '0;
         llc_ff       <= '0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         epp_ff       <= epp_in;
         nodes_ff     <= nodes_in;
         fill_ff      <= fill_in;
         cfp_ff       <= cfp_in;
         nfp_ff       <= nfp_in;
         llc_ff       <= llc_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      large_ff    <= large_in;
      final_ff    <= final_in;
      close_ff    <= close_in;
      size_ff     <= size_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      status.div_done    = div_done;
      status.is_large    = large_ff;
      status.close_chunk = close_ff;
      status.final_node  = final_ff;
      status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/lpla_controller.sv @@
// ----------------------------------------------------------------------------
// lpla_controller
// Sequences one node: accept, divide, then up to three result records.
// ----------------------------------------------------------------------------
module lpla_controller
   import lpla_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LARGE,
      ST_CHUNK,
      ST_TOTAL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               if (status.is_large) begin
                  state_in = ST_LARGE;
               end else begin
                  cmd.apply_small = 1'b1;
                  state_in = status.close_chunk ? ST_CHUNK : ST_IDLE;
               end
            end
         end
         ST_LARGE: begin
            if (status.rsp_free) begin
               cmd.emit_large = 1'b1;
               cmd.last       = !status.close_chunk;
               state_in       = status.close_chunk ? ST_CHUNK : ST_IDLE;
            end
         end
         ST_CHUNK: begin
            if (status.rsp_free) begin
               cmd.emit_chunk = 1'b1;
               cmd.last       = !status.final_node;
               state_in       = status.final_node ? ST_TOTAL : ST_IDLE;
            end
         end
         ST_TOTAL: begin
            if (status.rsp_free) begin
               cmd.emit_total = 1'b1;
               cmd.last       = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/list_page_layout_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// list_page_layout_allocator_unit
// Lays out per-node lists in pages and reports large list, chunk and total
// page records.
// ----------------------------------------------------------------------------
// Nodes arrive one transaction each, in node order. After a node is accepted
// it passes through the restoring divider, one quotient bit per cycle over a
// 33-bit dividend. Once the division is done the controller moves to the
// state of the first record, which loads it into the output register as soon
// as that register is free; each further record follows in its own state,
// held while rsp_stall keeps the register full. A large list reports its
// page run at once; each chunk of CHUNK_NODES nodes, or the final node,
// reports the chunk's shared pages, and the final node also reports the
// total page count and restarts the layout. A small list that closes no
// chunk gives no record, and the next node can be accepted as soon as its
// division is done. Otherwise the next node is taken once the last record
// of the current one sits in the output register. Write elems_per_page
// through csr_ only while idle; zero counts as one.
// ----------------------------------------------------------------------------
module list_page_layout_allocator_unit
   import lpla_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [EPP_W-1:0] csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   cmd_type    cmd;
   status_type status;

   lpla_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lpla_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_data       (req_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule
